/* hdl/mcsw_pkg.sv */
// Shared types and constants for the multi-channel software watchdog.
`default_nettype none

package mcsw_pkg;

    localparam int NUM_CHANNELS_DEF = 8;

    localparam int MODE_W      = 2;
    localparam int CHANNEL_W   = 8;
    localparam int TIMEOUT_W   = 32;
    localparam int EXP_CHAN_W  = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK = 2'd0,
        MODE_FEED = 2'd1,
        MODE_REG  = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_RESP = 3'b100
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept_item;
        logic walk_step;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic tick_go;
        logic walk_stop;
    } status_t;

endpackage

`default_nettype wire

/* hdl/mcsw_datapath.sv */
// Datapath of the watchdog: channel stores, halt latch, walk pointer and result registers.
`default_nettype none

module mcsw_datapath
    import mcsw_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cmd_t                  cmd,
    output status_t                    status,
    input  wire logic [MODE_W-1:0]     mode,
    input  wire logic [CHANNEL_W-1:0]  channel,
    input  wire logic [TIMEOUT_W-1:0]  timeout_ticks,
    input  wire logic                  run_enable,
    output logic                       accepted,
    output logic                       expired,
    output logic [EXP_CHAN_W-1:0]      expired_channel,
    output logic                       halted
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [TIMEOUT_W-1:0]  reload_reg [NUM_CHANNELS];
    logic [TIMEOUT_W-1:0]  count_reg  [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] run_reg;
    logic                  halt_reg;
    logic [IDX_W-1:0]      ptr_reg;
    logic                  accepted_reg;
    logic                  expired_reg;
    logic [EXP_CHAN_W-1:0] exp_chan_reg;

    logic                  in_range;
    logic [IDX_W-1:0]      addr;
    logic [TIMEOUT_W-1:0]  cur_count;
    logic                  cur_run;
    logic                  cur_zero;

    assign in_range  = ({1'b0, channel} < (CHANNEL_W+1)'(NUM_CHANNELS));
    assign addr      = cmd.walk_step ? ptr_reg : channel[IDX_W-1:0];
    assign cur_count = count_reg[addr];
    assign cur_run   = run_reg[addr];
    assign cur_zero  = (cur_count == '0);

    assign status.tick_go   = (mode_t'(mode) == MODE_TICK) && !halt_reg;
    assign status.walk_stop = (cur_run && cur_zero) || (ptr_reg == IDX_W'(NUM_CHANNELS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                reload_reg[i] <= '0;
                count_reg[i]  <= '0;
            end
            run_reg      <= '0;
            halt_reg     <= 1'b0;
            ptr_reg      <= '0;
            accepted_reg <= 1'b0;
            expired_reg  <= 1'b0;
            exp_chan_reg <= '0;
        end
        else if (cmd.accept_item)
        begin
            ptr_reg      <= '0;
            expired_reg  <= 1'b0;
            exp_chan_reg <= '0;
            accepted_reg <= 1'b1;
            unique case (mode_t'(mode))
                MODE_FEED:
                begin
                    if (in_range)
                    begin
                        count_reg[addr] <= reload_reg[addr];
                    end
                    else
                    begin
                        accepted_reg <= 1'b0;
                    end
                end
                MODE_REG:
                begin
                    if (in_range)
                    begin
                        reload_reg[addr] <= timeout_ticks;
                        count_reg[addr]  <= timeout_ticks;
                        run_reg[addr]    <= run_enable;
                        halt_reg         <= 1'b0;
                    end
                    else
                    begin
                        accepted_reg <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.walk_step)
        begin
            ptr_reg <= ptr_reg + 1'b1;
            if (cur_run)
            begin
                if (!cur_zero)
                begin
                    count_reg[addr] <= cur_count - 1'b1;
                end
                else
                begin
                    halt_reg     <= 1'b1;
                    expired_reg  <= 1'b1;
                    exp_chan_reg <= EXP_CHAN_W'(ptr_reg);
                end
            end
        end
    end

    assign accepted        = accepted_reg;
    assign expired         = expired_reg;
    assign expired_channel = exp_chan_reg;
    assign halted          = halt_reg;

    // While an expiry is reported, the halt latch is always set.
    assert property (@(posedge clk) disable iff (!rst_n) expired_reg |-> halt_reg)
        else $error("expired reported without halt latch");

endmodule

`default_nettype wire

/* hdl/mcsw_ctrl.sv */
// Controller state machine of the watchdog: accept, channel walk and result strobe.
`default_nettype none

module mcsw_ctrl
    import mcsw_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire status_t status,
    output cmd_t         cmd,
    output logic         busy,
    output logic         done
);

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next      = state_reg;
        cmd.accept_item = 1'b0;
        cmd.walk_step   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.accept_item = 1'b1;
                    state_next      = status.tick_go ? ST_WALK : ST_RESP;
                end
            end
            ST_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (status.walk_stop)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_RESP);

    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted transfer did not make the block busy");

    assert property (@(posedge clk) disable iff (!rst_n) done |=> (!done && !busy))
        else $error("result strobe longer than one cycle or block stayed busy");

    assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("result strobe while the block was idle");

endmodule

`default_nettype wire

/* hdl/multi_channel_soft_watchdog.sv */
// Top level of the multi-channel software watchdog.
`default_nettype none

// A transfer is taken at the rising clock edge where start is high and busy is low; the
// fields mode, channel, timeout_ticks and run_enable are sampled at that edge. Exactly one
// result follows per transfer: done is high for one cycle and accepted, expired,
// expired_channel and halted are valid in that cycle. The receiver cannot stall, so it must
// capture the result whenever done is seen. Feed, register, unused-mode and halted-tick
// items go straight to the result: done is high in the cycle right after the accepting
// edge. A tick that runs the walk visits one channel per cycle, starting at channel 0,
// through the single read port of the channel stores; it finishes at the first running
// channel already at zero or after the last channel, and done follows in the result state.
// Busy stays high through the result cycle, and the next transfer can be taken in the cycle
// after done. All channel stores and the halt latch are cleared by reset at once; there is
// no clearing pass.
module multi_channel_soft_watchdog
    import mcsw_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [MODE_W-1:0]     mode,
    input  wire logic [CHANNEL_W-1:0]  channel,
    input  wire logic [TIMEOUT_W-1:0]  timeout_ticks,
    input  wire logic                  run_enable,
    output logic                       done,
    output logic                       accepted,
    output logic                       expired,
    output logic [EXP_CHAN_W-1:0]      expired_channel,
    output logic                       halted
);

    cmd_t    cmd;
    status_t status;

    // The controller sequences each transfer; the datapath owns every store.
    mcsw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    mcsw_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .mode            (mode),
        .channel         (channel),
        .timeout_ticks   (timeout_ticks),
        .run_enable      (run_enable),
        .accepted        (accepted),
        .expired         (expired),
        .expired_channel (expired_channel),
        .halted          (halted)
    );

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the multi-channel software watchdog.
`default_nettype none

module tb;
    import mcsw_pkg::*;

    localparam int NUM_CHANNELS = 8;
    localparam int RANDOM_ITEMS = 500;
    // The longest correct stretch without any transfer or result is a long sender gap
    // plus one full channel walk, far below this limit.
    localparam int IDLE_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = NUM_CHANNELS + 4;

    // One result of the block, in port order.
    typedef struct packed {
        logic                  accepted;
        logic                  expired;
        logic [EXP_CHAN_W-1:0] expired_channel;
        logic                  halted;
    } watchdog_result_t;

    // One row of the directed stimulus. When has_fixed is set, the expected result is
    // taken from the row itself; otherwise it comes from the predictor.
    typedef struct packed {
        mode_t                 mode;
        logic [CHANNEL_W-1:0]  channel;
        logic [TIMEOUT_W-1:0]  timeout_ticks;
        logic                  run_enable;
        bit                    has_fixed;
        watchdog_result_t      fixed;
    } directed_row_t;

    localparam int DIRECTED_COUNT = 25;

    // The first rows cover reset state, out-of-range ids, the unused mode, an expiry at
    // zero, a tick and a feed while halted, and an out-of-range register that must not
    // clear the halt latch. Later rows walk expiries that stop the walk before a
    // higher channel, a stopped channel being skipped, and the largest timeout.
    localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{MODE_TICK, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1, '{1'b1, 1'b0, 3'd0, 1'b0}},
        '{MODE_FEED, 8'hFF, 32'h0000_0000, 1'b0, 1'b1, '{1'b0, 1'b0, 3'd0, 1'b0}},
        '{MODE_REG,  8'h08, 32'h0000_0005, 1'b1, 1'b1, '{1'b0, 1'b0, 3'd0, 1'b0}},
        '{MODE_NONE, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1, '{1'b1, 1'b0, 3'd0, 1'b0}},
        '{MODE_REG,  8'h00, 32'h0000_0000, 1'b1, 1'b1, '{1'b1, 1'b0, 3'd0, 1'b0}},
        '{MODE_TICK, 8'h00, 32'h0000_0000, 1'b0, 1'b1, '{1'b1, 1'b1, 3'd0, 1'b1}},
        '{MODE_TICK, 8'h00, 32'h0000_0000, 1'b0, 1'b1, '{1'b1, 1'b0, 3'd0, 1'b1}},
        '{MODE_FEED, 8'h00, 32'h0000_0000, 1'b0, 1'b1, '{1'b1, 1'b0, 3'd0, 1'b1}},
        '{MODE_REG,  8'hC8, 32'h0000_0001, 1'b1, 1'b1, '{1'b0, 1'b0, 3'd0, 1'b1}},
        '{MODE_REG,  8'h07, 32'hFFFF_FFFF, 1'b1, 1'b1, '{1'b1, 1'b0, 3'd0, 1'b0}},
        '{MODE_REG,  8'h00, 32'h0000_0002, 1'b1, 1'b1, '{1'b1, 1'b0, 3'd0, 1'b0}},
        '{MODE_TICK, 8'h00, 32'h0000_0000, 1'b0, 1'b0, '0},
        '{MODE_TICK, 8'h00, 32'h0000_0000, 1'b0, 1'b0, '0},
        '{MODE_TICK, 8'h00, 32'h0000_0000, 1'b0, 1'b0, '0},
        '{MODE_REG,  8'h00, 32'h0000_0005, 1'b0, 1'b0, '0},
        '{MODE_REG,  8'h03, 32'h0000_0001, 1'b1, 1'b0, '0},
        '{MODE_TICK, 8'h00, 32'h0000_0000, 1'b0, 1'b0, '0},
        '{MODE_TICK, 8'h00, 32'h0000_0000, 1'b0, 1'b0, '0},
        '{MODE_FEED, 8'h03, 32'h0000_0000, 1'b0, 1'b0, '0},
        '{MODE_REG,  8'h03, 32'h0000_0003, 1'b1, 1'b0, '0},
        '{MODE_FEED, 8'h07, 32'h0000_0000, 1'b0, 1'b0, '0},
        '{MODE_TICK, 8'h00, 32'h0000_0000, 1'b0, 1'b0, '0},
        '{MODE_NONE, 8'h00, 32'h0000_0000, 1'b0, 1'b0, '0},
        '{MODE_REG,  8'h07, 32'h0000_0000, 1'b0, 1'b0, '0},
        '{MODE_TICK, 8'h00, 32'h0000_0000, 1'b0, 1'b0, '0}
    };

    // Every input starts at a known value before the first clock edge.
    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 start         = 1'b0;
    logic [MODE_W-1:0]    mode          = '0;
    logic [CHANNEL_W-1:0] channel       = '0;
    logic [TIMEOUT_W-1:0] timeout_ticks = '0;
    logic                 run_enable    = 1'b0;

    logic                  busy;
    logic                  done;
    logic                  accepted;
    logic                  expired;
    logic [EXP_CHAN_W-1:0] expired_channel;
    logic                  halted;

    // Private copy of the channel bank, updated once per accepted transfer.
    logic [TIMEOUT_W-1:0] reload_shadow [NUM_CHANNELS];
    logic [TIMEOUT_W-1:0] counter_shadow [NUM_CHANNELS];
    logic                 run_shadow [NUM_CHANNELS];
    logic                 halt_shadow;

    // Results that have been predicted but have not yet appeared on the result ports.
    watchdog_result_t pending_results [$];

    int unsigned error_count  = 0;
    int unsigned result_count = 0;
    int unsigned idle_cycles  = 0;

    multi_channel_soft_watchdog #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .channel        (channel),
        .timeout_ticks  (timeout_ticks),
        .run_enable     (run_enable),
        .done           (done),
        .accepted       (accepted),
        .expired        (expired),
        .expired_channel(expired_channel),
        .halted         (halted)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Applies one item to the shadow bank and returns the result it causes. A tick walks
    // the channels upward unless halted, counting down running channels, and stops at the
    // first running channel already at zero, so later channels keep their count that tick.
    function automatic watchdog_result_t predict_watchdog(mode_t m, logic [CHANNEL_W-1:0] ch,
                                                          logic [TIMEOUT_W-1:0] ticks,
                                                          logic run);
        watchdog_result_t r;
        bit               walk_over;
        r = '{accepted: 1'b1, expired: 1'b0, expired_channel: '0, halted: 1'b0};
        walk_over = 1'b0;
        if (m == MODE_FEED || m == MODE_REG)
        begin
            if (ch >= NUM_CHANNELS)
            begin
                r.accepted = 1'b0;
            end
            else if (m == MODE_FEED)
            begin
                counter_shadow[ch] = reload_shadow[ch];
            end
            else
            begin
                reload_shadow[ch]  = ticks;
                counter_shadow[ch] = ticks;
                run_shadow[ch]     = run;
                halt_shadow        = 1'b0;
            end
        end
        else if (m == MODE_TICK && !halt_shadow)
        begin
            for (int k = 0; k < NUM_CHANNELS && !walk_over; k++)
            begin
                if (run_shadow[k])
                begin
                    if (counter_shadow[k] != 0)
                    begin
                        counter_shadow[k] = counter_shadow[k] - 1;
                    end
                    else
                    begin
                        halt_shadow       = 1'b1;
                        r.expired         = 1'b1;
                        r.expired_channel = EXP_CHAN_W'(k);
                        walk_over         = 1'b1;
                    end
                end
            end
        end
        r.halted = halt_shadow;
        return r;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("MISMATCH result %0d %s: got %0d, expected %0d", result_count, what, got, want);
        error_count++;
    endtask

    // Presents one item and holds it until a transfer takes place. The transfer happens at
    // the first edge where busy is low, since start is already high at that edge. The
    // expected result is queued right there, so the queue stays in transfer order.
    task automatic send_item(mode_t m, logic [CHANNEL_W-1:0] ch, logic [TIMEOUT_W-1:0] ticks,
                             logic run, bit has_fixed, watchdog_result_t fixed);
        watchdog_result_t predicted;
        start         <= 1'b1;
        mode          <= m;
        channel       <= ch;
        timeout_ticks <= ticks;
        run_enable    <= run;
        forever
        begin
            @(posedge clk);
            if (!busy)
            begin
                break;
            end
        end
        predicted = predict_watchdog(m, ch, ticks, run);
        pending_results.push_back(has_fixed ? fixed : predicted);
    endtask

    // Random gap after a transfer: mostly none, sometimes a few cycles, rarely a long one.
    // With no gap, start simply stays high for the next item.
    task automatic idle_gap();
        int unsigned pick;
        int unsigned gap;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            gap = 0;
        end
        else if (pick < 90)
        begin
            gap = $urandom_range(4, 1);
        end
        else
        begin
            gap = $urandom_range(40, 10);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Holds the sender off until every outstanding result has arrived.
    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Result checker. The strobe and the result fields are sampled at the edge that ends
    // the result cycle, and each result is compared with the oldest expectation.
    always @(posedge clk)
    begin
        watchdog_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("arrived with nothing pending", 1, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (accepted !== want.accepted)
                begin
                    report_mismatch("accepted", accepted, want.accepted);
                end
                if (expired !== want.expired)
                begin
                    report_mismatch("expired", expired, want.expired);
                end
                if (expired_channel !== want.expired_channel)
                begin
                    report_mismatch("expired_channel", expired_channel, want.expired_channel);
                end
                if (halted !== want.halted)
                begin
                    report_mismatch("halted", halted, want.halted);
                end
            end
            result_count++;
        end
    end

    // Watchdog on the run itself: any cycle with neither a transfer nor a result counts
    // toward the limit, and a transfer or a result starts the count over.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin : stimulus
        int unsigned      pick;
        mode_t            m;
        logic [CHANNEL_W-1:0] ch;
        logic [TIMEOUT_W-1:0] ticks;
        logic             run;

        for (int k = 0; k < NUM_CHANNELS; k++)
        begin
            reload_shadow[k]  = '0;
            counter_shadow[k] = '0;
            run_shadow[k]     = 1'b0;
        end
        halt_shadow = 1'b0;

        // Reset is applied once and released at a rising edge.
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            send_item(DIRECTED_ROWS[i].mode, DIRECTED_ROWS[i].channel,
                      DIRECTED_ROWS[i].timeout_ticks, DIRECTED_ROWS[i].run_enable,
                      DIRECTED_ROWS[i].has_fixed, DIRECTED_ROWS[i].fixed);
            idle_gap();
        end

        // Random part. Small timeouts on mostly valid channels keep channels expiring and
        // being re-registered, so the walk reaches every channel position often; wide and
        // near-maximum timeouts, out-of-range ids and the unused mode are mixed in.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                m = MODE_TICK;
            end
            else if (pick < 65)
            begin
                m = MODE_FEED;
            end
            else if (pick < 94)
            begin
                m = MODE_REG;
            end
            else
            begin
                m = MODE_NONE;
            end

            if ($urandom_range(99) < 85)
            begin
                ch = CHANNEL_W'($urandom_range(NUM_CHANNELS - 1));
            end
            else
            begin
                ch = CHANNEL_W'($urandom_range(255, NUM_CHANNELS));
            end

            pick = $urandom_range(99);
            if (pick < 80)
            begin
                ticks = TIMEOUT_W'($urandom_range(8));
            end
            else if (pick < 90)
            begin
                ticks = $urandom;
            end
            else
            begin
                ticks = 32'hFFFF_FFFF - TIMEOUT_W'($urandom_range(3));
            end

            run = ($urandom_range(99) < 75);

            send_item(m, ch, ticks, run, 1'b0, '0);
            if (n == RANDOM_ITEMS / 2)
            begin
                drain_results();
            end
            else
            begin
                idle_gap();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            report_mismatch("expectations left at end", 0, pending_results.size());
        end

        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
